[rtl/swm_pkg.sv]
// swm_pkg: shared types and constants for the sliding window median block.
// Used by swm_ctrl, swm_datapath and sliding_window_median.
package swm_pkg;

   localparam int CSR_ADDR_BITS = 2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_WINDOW_SIZE = 2'd0;
   localparam int WS_BITS = 13;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HIST_RD,
      ST_HIST_WAIT,
      ST_DEC_RD,
      ST_DEC_WR,
      ST_INC_RD,
      ST_INC_WR,
      ST_FIND_RD,
      ST_FIND_STEP,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic clear_start;
      logic clear_step;
      logic accept;
      logic hist_rd;
      logic hist_latch;
      logic dec_start;
      logic inc_start;
      logic path_rd;
      logic path_wr;
      logic find_start;
      logic find_rd;
      logic find_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic window_full;
      logic path_done;
      logic find_done;
   } status_type;

endpackage

[rtl/swm_ctrl.sv]
// swm_ctrl: sequencer for one transaction (remove oldest, add new, rank walk).
// Depends on swm_pkg.
module swm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                cfg_write,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                out_busy,
   input  swm_pkg::status_type status,
   output swm_pkg::cmd_type    cmd
);

   swm_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= swm_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         swm_pkg::ST_CLEAR:     if (status.clear_done) state_in = swm_pkg::ST_IDLE;
         swm_pkg::ST_IDLE:      if (req_tvalid) state_in = swm_pkg::ST_HIST_RD;
         swm_pkg::ST_HIST_RD:   state_in = swm_pkg::ST_HIST_WAIT;
         swm_pkg::ST_HIST_WAIT: state_in = status.window_full ? swm_pkg::ST_DEC_RD
                                                              : swm_pkg::ST_INC_RD;
         swm_pkg::ST_DEC_RD:    state_in = swm_pkg::ST_DEC_WR;
         swm_pkg::ST_DEC_WR:    if (status.path_done) state_in = swm_pkg::ST_INC_RD;
                                else state_in = swm_pkg::ST_DEC_RD;
         swm_pkg::ST_INC_RD:    state_in = swm_pkg::ST_INC_WR;
         swm_pkg::ST_INC_WR:    if (status.path_done) begin
                                   state_in = status.window_full ? swm_pkg::ST_FIND_RD
                                                                 : swm_pkg::ST_IDLE;
                                end else state_in = swm_pkg::ST_INC_RD;
         swm_pkg::ST_FIND_RD:   state_in = swm_pkg::ST_FIND_STEP;
         swm_pkg::ST_FIND_STEP: if (status.find_done) state_in = swm_pkg::ST_OUT;
                                else state_in = swm_pkg::ST_FIND_RD;
         swm_pkg::ST_OUT:       if (!out_busy) state_in = swm_pkg::ST_IDLE;
         default:               state_in = swm_pkg::ST_CLEAR;
      endcase
      if (cfg_write) state_in = swm_pkg::ST_CLEAR;
   end

   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      case (state_ff)
         swm_pkg::ST_CLEAR:     cmd.clear_step = 1'b1;
         swm_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         swm_pkg::ST_HIST_RD:   cmd.hist_rd = 1'b1;
         swm_pkg::ST_HIST_WAIT: begin
            cmd.hist_latch = 1'b1;
            cmd.dec_start  = status.window_full;
            cmd.inc_start  = !status.window_full;
         end
         swm_pkg::ST_DEC_RD:    cmd.path_rd = 1'b1;
         swm_pkg::ST_DEC_WR: begin
            cmd.path_wr   = 1'b1;
            cmd.inc_start = status.path_done;
         end
         swm_pkg::ST_INC_RD:    cmd.path_rd = 1'b1;
         swm_pkg::ST_INC_WR: begin
            cmd.path_wr    = 1'b1;
            cmd.find_start = status.path_done && status.window_full;
         end
         swm_pkg::ST_FIND_RD:   cmd.find_rd = 1'b1;
         swm_pkg::ST_FIND_STEP: cmd.find_step = 1'b1;
         swm_pkg::ST_OUT:       cmd.out_load = !out_busy;
         default:               cmd = '0;
      endcase
      if (cfg_write) begin
         cmd = '0;
         cmd.clear_start = 1'b1;
         req_tready = 1'b0;
      end
   end

   a_tready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == swm_pkg::ST_IDLE) else $error("tready outside idle");
   a_cfg_clears: assert property (@(posedge clock) disable iff (reset)
      cfg_write |=> state_ff == swm_pkg::ST_CLEAR) else $error("config did not clear");
   a_out_once: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> state_ff != swm_pkg::ST_OUT) else $error("double result");

endmodule

[rtl/swm_datapath.sv]
// swm_datapath: history ring, count tree memory, rank walk and output stage.
// Depends on swm_pkg.
module swm_datapath #(
   parameter int VALUE_BITS = 16,
   parameter int WINDOW_MAX = 4096
) (
   input  logic                    clock,
   input  logic                    reset,
   input  swm_pkg::cmd_type        cmd,
   output swm_pkg::status_type     status,
   input  logic [swm_pkg::WS_BITS-1:0] window_size,
   input  logic [15:0]             sample,
   output logic                    out_busy,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [15:0]             rsp_tdata
);

   localparam int LEAVES   = 1 << VALUE_BITS;
   localparam int NODES    = 2 * LEAVES;
   localparam int NB       = VALUE_BITS + 1;
   localparam int HB       = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CB       = $clog2(WINDOW_MAX + 1);
   localparam int LB       = $clog2(VALUE_BITS + 1);

   // counts: node index n in 1..NODES-1, heap layout
   logic [CB-1:0]         tree_mem [NODES];
   logic [VALUE_BITS-1:0] hist_mem [WINDOW_MAX];

   logic [CB-1:0]         win_ff, win_in;
   logic [CB-1:0]         fill_ff;
   logic [HB-1:0]         slot_ff;
   logic [VALUE_BITS-1:0] new_ff, hist_rd_ff;
   logic [NB-1:0]         clr_ff;
   logic                  clr_busy_ff;
   logic [NB-1:0]         node_ff;
   logic                  up_ff;
   logic [CB-1:0]         rd_ff;
   logic [CB-1:0]         rank_ff;
   logic [LB-1:0]         lvl_ff;
   logic                  valid_ff;
   logic [15:0]           data_ff;

   logic [NB-1:0] rd_addr, wr_addr;
   logic [CB-1:0] wr_data;
   logic          wr_en;
   logic [CB-1:0] rank_init;

   always_comb begin
      win_in = CB'(window_size);
      if (window_size == '0) win_in = CB'(1);
      if ({19'd0, window_size} > 32'(WINDOW_MAX)) win_in = CB'(WINDOW_MAX);
   end

   assign status.clear_done  = clr_busy_ff && clr_ff == NB'(NODES - 1);
   assign status.window_full = fill_ff == win_ff;
   assign status.path_done   = node_ff == NB'(1);
   assign status.find_done   = lvl_ff == LB'(1);
   assign rank_init = CB'((({1'b0, win_ff} + 1'b1) >> 1));
   assign out_busy = valid_ff;

   // tree memory: one write and one read port
   always_comb begin
      wr_en   = clr_busy_ff || cmd.path_wr;
      wr_addr = clr_busy_ff ? clr_ff : node_ff;
      wr_data = clr_busy_ff ? '0 : (up_ff ? rd_ff + 1'b1 : rd_ff - 1'b1);
      rd_addr = cmd.find_rd ? {node_ff[NB-2:0], 1'b0} : node_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) tree_mem[wr_addr] <= wr_data;
      rd_ff <= tree_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) new_ff <= VALUE_BITS'(sample);
      if (cmd.hist_latch) hist_mem[slot_ff] <= new_ff;
      if (cmd.hist_rd) hist_rd_ff <= hist_mem[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= CB'(1);
         fill_ff <= '0;
         slot_ff <= '0;
         clr_ff <= '0;
         clr_busy_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         if (cmd.clear_start) begin
            win_ff <= win_in;
            fill_ff <= '0;
            slot_ff <= '0;
            clr_ff <= '0;
            clr_busy_ff <= 1'b1;
            valid_ff <= 1'b0;
         end else begin
            if (cmd.clear_step && !clr_busy_ff) begin
               clr_ff <= '0;
               clr_busy_ff <= 1'b1;
            end else if (clr_busy_ff) begin
               clr_ff <= clr_ff + 1'b1;
               if (status.clear_done) clr_busy_ff <= 1'b0;
            end
            if (cmd.hist_latch && !status.window_full) fill_ff <= fill_ff + 1'b1;
            if (cmd.hist_latch)
               slot_ff <= ({1'b0, slot_ff} + 1'b1 == (HB+1)'(win_ff)) ? '0 : slot_ff + 1'b1;
            if (cmd.out_load) valid_ff <= 1'b1;
            else if (rsp_tready) valid_ff <= 1'b0;
         end
      end
   end

   // slot uses pre-write value: history read of the slot being overwritten
   always_ff @(posedge clock) begin
      if (cmd.dec_start) begin
         node_ff <= NB'(LEAVES) | NB'(hist_rd_ff);
         up_ff   <= 1'b0;
      end else if (cmd.inc_start) begin
         node_ff <= NB'(LEAVES) | NB'(new_ff);
         up_ff   <= 1'b1;
      end else if (cmd.find_start) begin
         node_ff <= NB'(1);
         rank_ff <= rank_init;
         lvl_ff  <= LB'(VALUE_BITS);
      end else if (cmd.path_wr) begin
         node_ff <= node_ff >> 1;
      end else if (cmd.find_step) begin
         lvl_ff <= lvl_ff - 1'b1;
         if (rank_ff <= rd_ff) begin
            node_ff <= {node_ff[NB-2:0], 1'b0};
         end else begin
            rank_ff <= rank_ff - rd_ff;
            node_ff <= {node_ff[NB-2:0], 1'b1};
         end
      end
      if (cmd.out_load) data_ff <= 16'(node_ff[VALUE_BITS-1:0]);
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= win_ff) else $error("fill above window");
   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, slot_ff} < (HB+1)'(win_ff)) else $error("slot out of window");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready && !cmd.clear_start |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

endmodule

[rtl/sliding_window_median.sv]
// Sliding window median filter, top level.
// Usage: write window_size (1..WINDOW_MAX; 0 acts as 1, larger as WINDOW_MAX)
// over the csr_ APB port at byte address 0 while idle; this empties the window.
// req_ stream: one sample per transaction in tdata[15:0].
// rsp_ stream: median in tdata[15:0], the ((W+1)/2)-th smallest of the last
// W samples; no transaction while the window is still filling.
// With a full window a sample takes, from acceptance to the next req_tready,
// two leaf-to-root count updates (read and write per level, root included)
// and one root-to-leaf rank walk (a read and a step per level) through the
// count memory. While the window fills a sample takes only the leaf-to-root
// update for the new sample.
// After reset and after each window_size write, a clearing pass zeroes the
// count memory; req_tready stays low.
// A finished median sits in an output register and the next sample is still
// taken; only when the next median is ready while that register is still
// held by a low rsp_tready does the sequencer wait, with req_tready low.
// Depends on swm_pkg, swm_ctrl, swm_datapath.
module sliding_window_median #(
   parameter int VALUE_BITS = 16,
   parameter int WINDOW_MAX = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] median
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [swm_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   swm_pkg::cmd_type    cmd;
   swm_pkg::status_type status;
   logic [swm_pkg::WS_BITS-1:0] ws_ff;
   logic cfg_write, out_busy;

   assign csr_pready = 1'b1;
   assign cfg_write = csr_psel && csr_penable && csr_pwrite
                      && csr_paddr == swm_pkg::CSR_WINDOW_SIZE;
   assign csr_prdata = (csr_paddr == swm_pkg::CSR_WINDOW_SIZE) ? {19'd0, ws_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) ws_ff <= swm_pkg::WS_BITS'(1);
      else if (cfg_write) ws_ff <= csr_pwdata[swm_pkg::WS_BITS-1:0];
   end

   swm_ctrl u_ctrl (
      .clock, .reset, .cfg_write, .req_tvalid, .req_tready,
      .out_busy, .status, .cmd
   );

   swm_datapath #(.VALUE_BITS(VALUE_BITS), .WINDOW_MAX(WINDOW_MAX)) u_dp (
      .clock, .reset, .cmd, .status,
      .window_size(cfg_write ? csr_pwdata[swm_pkg::WS_BITS-1:0] : ws_ff),
      .sample(req_tdata), .out_busy, .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

endmodule
